// File: sv/sfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfl_pkg: shared types and constants of the segregated free list index
// Field widths, action codes and parameter defaults used by the top level.
// ----------------------------------------------------------------------------
package sfl_pkg;

    // Parameter defaults
    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int SIZE_CLASSES_DEF = 8;

    // Upper bound of the smallest size class; each higher class doubles it
    localparam int MIN_CLASS_BYTES  = 8;

    // Field widths of the item channels
    localparam int ACTION_W = 2;
    localparam int ID_W     = 8;
    localparam int BYTES_W  = 32;
    localparam int PROBE_W  = 9;

    // Saturation value of the probe counter
    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_FIND   = 2'd3
    } action_t;

endpackage

`default_nettype wire

// File: sv/segregated_free_list_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segregated_free_list_index: size-class free list index for a heap allocator
// Keeps free blocks on doubly linked size-class lists and serves clear,
// insert, remove and first-fit find requests.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one request item: action,
//   block_id and block_bytes. Output channel (out_valid / out_stall) returns
//   one result item per request: found, found_block and probe_count (all
//   zero for clear, insert and remove).
//   One request is worked on at a time; in_stall stays high until its result
//   has been loaded into the output register.
//   Steps: clear, and an out-of-range insert or remove, go straight to S_DONE;
//   insert writes the node (S_INS1), then links the old head (S_INS2); remove
//   fetches the node (S_RM1), then unlinks it (S_RM2); find reads the class
//   head (S_F0), walks its own list (S_FCMP) and, failing that, scans higher
//   classes (S_FSCAN). With the output free, in_stall falls as out_valid rises.
//   The find walk reads one list node per cycle from the size and link RAMs
//   (registered read, address fed straight from the previous node's link);
//   the higher-class scan inspects one class head per cycle.
//   A stalled result holds in the output register; the finished next result
//   waits in the sequencer until the register is free.
//   Reset empties all class lists. The node RAMs are not cleared: the user must
//   see that an entry is only read after an insert wrote it; not enforced here.
// ----------------------------------------------------------------------------
module segregated_free_list_index
    import sfl_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int SIZE_CLASSES = SIZE_CLASSES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [ID_W-1:0]     block_id,
    input  wire logic [BYTES_W-1:0]  block_bytes,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     found,
    output logic [ID_W-1:0]          found_block,
    output logic [PROBE_W-1:0]       probe_count
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int LINK_W = IDX_W + 1;
    localparam int CLS_W  = $clog2(SIZE_CLASSES);
    localparam int STEP_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INS1  = 9'b000000010,
        S_INS2  = 9'b000000100,
        S_RM1   = 9'b000001000,
        S_RM2   = 9'b000010000,
        S_F0    = 9'b000100000,
        S_FCMP  = 9'b001000000,
        S_FSCAN = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    // Size class of a byte count: first class whose bound covers it
    function automatic logic [CLS_W-1:0] class_of(input logic [BYTES_W-1:0] size);
        logic [CLS_W-1:0] c;
        c = CLS_W'(SIZE_CLASSES - 1);
        for (int k = SIZE_CLASSES - 2; k >= 0; k--)
        begin
            if ({1'b0, size} <= ((BYTES_W+1)'(MIN_CLASS_BYTES) << k))
            begin
                c = CLS_W'(k);
            end
        end
        return c;
    endfunction

    // Control state
    state_t                state_reg, state_next;
    logic                  out_valid_reg;
    logic [IDX_W-1:0]      class_head_reg [SIZE_CLASSES];
    logic [SIZE_CLASSES-1:0] nonempty_reg;

    // Working registers
    logic [IDX_W-1:0]      id_reg, id_next;
    logic [BYTES_W-1:0]    bytes_reg, bytes_next;
    logic [CLS_W:0]        cls_reg, cls_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [STEP_W-1:0]     steps_reg, steps_next;
    logic [PROBE_W-1:0]    probe_reg, probe_next;
    logic                  res_found_reg, res_found_next;
    logic [ID_W-1:0]       res_blk_reg, res_blk_next;

    // Output registers
    logic                  found_reg;
    logic [ID_W-1:0]       found_block_reg;
    logic [PROBE_W-1:0]    probe_count_reg;

    // Class table update
    logic                  clear_all;
    logic                  head_we;
    logic [IDX_W-1:0]      head_wdata;
    logic                  ne_wdata;

    // Shared class encoder and selected class head
    logic [BYTES_W-1:0]    enc_in;
    logic [CLS_W-1:0]      class_enc;
    logic [CLS_W-1:0]      cls_sel;
    logic [IDX_W-1:0]      head_rd;
    logic                  head_ne;

    // RAM ports
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  size_we;
    logic [IDX_W-1:0]      size_waddr;
    logic [BYTES_W-1:0]    size_wdata;
    logic [BYTES_W-1:0]    size_rd;
    logic                  next_we;
    logic [IDX_W-1:0]      next_waddr;
    logic [LINK_W-1:0]     next_wdata;
    logic [LINK_W-1:0]     next_rd;
    logic                  prev_we;
    logic [IDX_W-1:0]      prev_waddr;
    logic [LINK_W-1:0]     prev_wdata;
    logic [LINK_W-1:0]     prev_rd;

    logic                  id_in_range;
    logic [PROBE_W-1:0]    probe_inc;
    logic                  out_load;

    // Node tables
    sfl_ram #(.WIDTH(BYTES_W), .DEPTH(MAX_BLOCKS)) u_size_ram (
        .clk     (clk),
        .wr_en   (size_we),
        .wr_addr (size_waddr),
        .wr_data (size_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (size_rd)
    );

    sfl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BLOCKS)) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_waddr),
        .wr_data (next_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    sfl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BLOCKS)) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_waddr),
        .wr_data (prev_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (prev_rd)
    );

    // Classify the request size on accept, the stored size during remove
    assign enc_in    = (state_reg == S_IDLE) ? block_bytes : size_rd;
    assign class_enc = class_of(enc_in);
    assign cls_sel   = (state_reg == S_RM2) ? class_enc : cls_reg[CLS_W-1:0];
    assign head_rd   = class_head_reg[cls_sel];
    assign head_ne   = nonempty_reg[cls_sel];

    assign id_in_range = (32'(block_id) < 32'(MAX_BLOCKS));
    assign probe_inc   = (probe_reg == PROBE_MAX) ? probe_reg : probe_reg + 1'b1;
    assign out_load    = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign in_stall = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        bytes_next     = bytes_reg;
        cls_next       = cls_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        probe_next     = probe_reg;
        res_found_next = res_found_reg;
        res_blk_next   = res_blk_reg;
        clear_all      = 1'b0;
        head_we        = 1'b0;
        head_wdata     = '0;
        ne_wdata       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = id_reg;
        size_we        = 1'b0;
        size_waddr     = id_reg;
        size_wdata     = bytes_reg;
        next_we        = 1'b0;
        next_waddr     = id_reg;
        next_wdata     = '0;
        prev_we        = 1'b0;
        prev_waddr     = id_reg;
        prev_wdata     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next        = IDX_W'(block_id);
                    bytes_next     = block_bytes;
                    cls_next       = {1'b0, class_enc};
                    steps_next     = '0;
                    probe_next     = '0;
                    res_found_next = 1'b0;
                    res_blk_next   = '0;
                    unique case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            clear_all  = 1'b1;
                            state_next = S_DONE;
                        end
                        ACT_INSERT: state_next = id_in_range ? S_INS1 : S_DONE;
                        ACT_REMOVE: state_next = id_in_range ? S_RM1 : S_DONE;
                        ACT_FIND:   state_next = S_F0;
                        default:    state_next = S_DONE;
                    endcase
                end
            end

            // Record the size and link the new block in front of the old head
            S_INS1:
            begin
                size_we    = 1'b1;
                next_we    = 1'b1;
                next_wdata = head_ne ? {1'b1, head_rd} : '0;
                prev_we    = 1'b1;
                prev_wdata = '0;
                state_next = S_INS2;
            end

            // Back-link the old head and make the block the new head
            S_INS2:
            begin
                if (head_ne)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = head_rd;
                    prev_wdata = {1'b1, id_reg};
                end
                head_we    = 1'b1;
                head_wdata = id_reg;
                ne_wdata   = 1'b1;
                state_next = S_DONE;
            end

            // Fetch the node to unlink
            S_RM1:
            begin
                rd_en      = 1'b1;
                state_next = S_RM2;
            end

            // Bypass the node in its neighbours or in the class head
            S_RM2:
            begin
                if (prev_rd[IDX_W])
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd[IDX_W-1:0];
                    next_wdata = next_rd;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = next_rd[IDX_W] ? next_rd[IDX_W-1:0] : '0;
                    ne_wdata   = next_rd[IDX_W];
                end
                if (next_rd[IDX_W])
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd[IDX_W-1:0];
                    prev_wdata = prev_rd;
                end
                state_next = S_DONE;
            end

            // Start the walk at the head of the own class
            S_F0:
            begin
                if (head_ne)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_rd;
                    cur_next   = head_rd;
                    state_next = S_FCMP;
                end
                else
                begin
                    cls_next   = cls_reg + 1'b1;
                    state_next = S_FSCAN;
                end
            end

            // Compare one node per cycle, fetching its successor at once
            S_FCMP:
            begin
                probe_next = probe_inc;
                steps_next = steps_reg + 1'b1;
                if (size_rd >= bytes_reg)
                begin
                    res_found_next = 1'b1;
                    res_blk_next   = ID_W'(cur_reg);
                    state_next     = S_DONE;
                end
                else if (next_rd[IDX_W] && (steps_reg != STEP_W'(MAX_BLOCKS - 1)))
                begin
                    rd_en    = 1'b1;
                    rd_addr  = next_rd[IDX_W-1:0];
                    cur_next = next_rd[IDX_W-1:0];
                end
                else
                begin
                    cls_next   = cls_reg + 1'b1;
                    state_next = S_FSCAN;
                end
            end

            // Take the head of the first non-empty higher class
            S_FSCAN:
            begin
                if (cls_reg >= (CLS_W+1)'(SIZE_CLASSES))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    probe_next = probe_inc;
                    if (head_ne)
                    begin
                        res_found_next = 1'b1;
                        res_blk_next   = ID_W'(head_rd);
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cls_next = cls_reg + 1'b1;
                    end
                end
            end

            // Hand the result over once the output register is free
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            nonempty_reg  <= '0;
            for (int i = 0; i < SIZE_CLASSES; i++)
            begin
                class_head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear_all)
            begin
                nonempty_reg <= '0;
                for (int i = 0; i < SIZE_CLASSES; i++)
                begin
                    class_head_reg[i] <= '0;
                end
            end
            else if (head_we)
            begin
                class_head_reg[cls_sel] <= head_wdata;
                nonempty_reg[cls_sel]   <= ne_wdata;
            end
        end
    end

    // Working and output registers
    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        bytes_reg     <= bytes_next;
        cls_reg       <= cls_next;
        cur_reg       <= cur_next;
        steps_reg     <= steps_next;
        probe_reg     <= probe_next;
        res_found_reg <= res_found_next;
        res_blk_reg   <= res_blk_next;
        if (out_load)
        begin
            found_reg       <= res_found_reg;
            found_block_reg <= res_blk_reg;
            probe_count_reg <= probe_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign found_block = found_block_reg;
    assign probe_count = probe_count_reg;

    // A result appears only from the hand-over state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised without a finished request");

    // A miss reports no block
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (found_block == '0))
        else $error("miss carries a block index");

    // A hit always examined at least one entry or class head
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (probe_count != '0))
        else $error("hit with zero probes");

    // The own-class walk is bounded by the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FCMP) |-> (steps_reg < STEP_W'(MAX_BLOCKS)))
        else $error("list walk ran past the table size");

endmodule

`default_nettype wire

// File: sv/sfl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfl_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: test/segregated_free_list_index_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segregated_free_list_index_tb: self-checking bench for the free list index
// Sends a short table of hand-picked requests, then three phases of random
// insert, remove, find and clear traffic with varying idle on both channels.
// Every returned item is compared field by field with a behavioural shadow
// of the size-class lists kept inside the bench.
// ----------------------------------------------------------------------------
module segregated_free_list_index_tb;
    import sfl_pkg::*;

    localparam int NODES        = MAX_BLOCKS_DEF;
    localparam int CLASSES      = SIZE_CLASSES_DEF;
    localparam int VALID_BIT    = ID_W;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 10;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int REPORT_LIMIT = 10;
    localparam int N_DIRECTED   = 25;

    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    block;
        logic [PROBE_W-1:0] probes;
    } result_t;

    typedef struct packed {
        action_t            act;
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic               typed;
        result_t            res;
    } stim_row_t;

    localparam result_t ZERO_RESULT = '{1'b0, 8'd0, 9'd0};

    // Hand-picked requests; typed rows carry an expectation that is plain at
    // a glance, the rest are checked against the shadow lists
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ACT_FIND,   8'd0,   32'd0,          1'b1, '{1'b0, 8'd0, 9'd7}},
        '{ACT_FIND,   8'd0,   32'hFFFF_FFFF,  1'b1, '{1'b0, 8'd0, 9'd0}},
        '{ACT_INSERT, 8'd0,   32'd0,          1'b1, ZERO_RESULT},
        '{ACT_INSERT, 8'd255, 32'hFFFF_FFFF,  1'b1, ZERO_RESULT},
        '{ACT_INSERT, 8'd10,  32'd8,          1'b1, ZERO_RESULT},
        '{ACT_INSERT, 8'd11,  32'd9,          1'b1, ZERO_RESULT},
        '{ACT_INSERT, 8'd12,  32'd512,        1'b1, ZERO_RESULT},
        '{ACT_INSERT, 8'd13,  32'd513,        1'b1, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'd5,          1'b0, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'd0,          1'b0, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'd9,          1'b0, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'hFFFF_FFFF,  1'b0, ZERO_RESULT},
        '{ACT_REMOVE, 8'd10,  32'd0,          1'b1, ZERO_RESULT},
        '{ACT_REMOVE, 8'd255, 32'd0,          1'b1, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'd600,        1'b0, ZERO_RESULT},
        '{ACT_INSERT, 8'd20,  32'd100,        1'b1, ZERO_RESULT},
        '{ACT_INSERT, 8'd20,  32'd100,        1'b1, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'd120,        1'b0, ZERO_RESULT},
        '{ACT_REMOVE, 8'd10,  32'd0,          1'b1, ZERO_RESULT},
        '{ACT_CLEAR,  8'hAA,  32'h5555_5555,  1'b1, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'd0,          1'b1, '{1'b0, 8'd0, 9'd7}},
        '{ACT_INSERT, 8'd5,   32'd64,         1'b1, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'd33,         1'b0, ZERO_RESULT},
        '{ACT_REMOVE, 8'd5,   32'd0,          1'b1, ZERO_RESULT},
        '{ACT_FIND,   8'd0,   32'd1,          1'b0, ZERO_RESULT}
    };

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [ACTION_W-1:0] action     = ACT_CLEAR;
    logic [ID_W-1:0]    block_id    = '0;
    logic [BYTES_W-1:0] block_bytes = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic               found;
    logic [ID_W-1:0]    found_block;
    logic [PROBE_W-1:0] probe_count;

    // Shadow of the list heads and node tables
    logic [ID_W-1:0]    head_block [CLASSES];
    logic               live_class [CLASSES];
    logic [ID_W:0]      next_link  [NODES];
    logic [ID_W:0]      prev_link  [NODES];
    logic [BYTES_W-1:0] node_size  [NODES];

    // Stimulus bookkeeping: what the caller believes is on the lists
    bit                 block_present [NODES];
    bit                 block_written [NODES];

    result_t            pending_answers [$];
    int                 fail_count  = 0;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;

    segregated_free_list_index DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .block_id    (block_id),
        .block_bytes (block_bytes),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .found_block (found_block),
        .probe_count (probe_count)
    );

    // Free-running clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Map a byte count to its size class
    function automatic int class_for_size(input logic [BYTES_W-1:0] bytes);
        for (int k = 0; k < CLASSES - 1; k++)
        begin
            if ({32'd0, bytes} <= (64'(MIN_CLASS_BYTES) << k))
                return k;
        end
        return CLASSES - 1;
    endfunction

    // Apply one request to the shadow lists and return the answer it gives
    function automatic result_t apply_request(input action_t act,
                                              input logic [ID_W-1:0] id,
                                              input logic [BYTES_W-1:0] bytes);
        result_t         res;
        int              c;
        logic            walking;
        logic [ID_W-1:0] cur;
        logic [ID_W:0]   nx;
        logic [ID_W:0]   pv;
        res = ZERO_RESULT;
        case (act)
            ACT_CLEAR:
            begin
                for (int k = 0; k < CLASSES; k++)
                begin
                    head_block[k] = '0;
                    live_class[k] = 1'b0;
                end
            end
            ACT_INSERT:
            begin
                c = class_for_size(bytes);
                node_size[id] = bytes;
                prev_link[id] = '0;
                if (live_class[c])
                begin
                    next_link[id] = {1'b1, head_block[c]};
                    prev_link[head_block[c]] = {1'b1, id};
                end
                else
                    next_link[id] = '0;
                head_block[c] = id;
                live_class[c] = 1'b1;
            end
            ACT_REMOVE:
            begin
                nx = next_link[id];
                pv = prev_link[id];
                if (pv[VALID_BIT])
                    next_link[pv[ID_W-1:0]] = nx;
                else
                begin
                    c = class_for_size(node_size[id]);
                    live_class[c] = nx[VALID_BIT];
                    head_block[c] = nx[VALID_BIT] ? nx[ID_W-1:0] : '0;
                end
                if (nx[VALID_BIT])
                    prev_link[nx[ID_W-1:0]] = pv;
            end
            ACT_FIND:
            begin
                c = class_for_size(bytes);
                walking = live_class[c];
                cur = head_block[c];
                // First fit along the own class, bounded against looped lists
                for (int steps = 0; steps < NODES && walking; steps++)
                begin
                    if (res.probes != PROBE_MAX)
                        res.probes = res.probes + 1'b1;
                    if (node_size[cur] >= bytes)
                    begin
                        res.found = 1'b1;
                        res.block = cur;
                        return res;
                    end
                    walking = next_link[cur][VALID_BIT];
                    cur = next_link[cur][ID_W-1:0];
                end
                // Then the head of the first non-empty larger class
                for (int k = c + 1; k < CLASSES; k++)
                begin
                    if (res.probes != PROBE_MAX)
                        res.probes = res.probes + 1'b1;
                    if (live_class[k])
                    begin
                        res.found = 1'b1;
                        res.block = head_block[k];
                        return res;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Draw a size, leaning on one class so that its list grows deep
    function automatic logic [BYTES_W-1:0] pick_size();
        int                 k;
        int                 pick;
        logic [BYTES_W-1:0] lo;
        logic [BYTES_W-1:0] hi;
        k = ($urandom_range(1) == 0) ? 3 : $urandom_range(CLASSES - 1);
        pick = $urandom_range(9);
        if (k == CLASSES - 1)
        begin
            lo = (MIN_CLASS_BYTES << (CLASSES - 2)) + 1;
            if (pick == 0)
                return '1;
            if (pick == 1)
                return lo;
            if (pick < 5)
                return $urandom;
            return $urandom_range(4096, lo);
        end
        lo = (k == 0) ? '0 : (MIN_CLASS_BYTES << (k - 1)) + 1;
        hi = MIN_CLASS_BYTES << k;
        if (pick == 0)
            return lo;
        if (pick == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    // Choose a block by its present state; ever_only keeps to written entries
    function automatic void pick_block(input bit want_present, input bit ever_only,
                                       output logic [ID_W-1:0] id, output bit ok);
        logic [ID_W-1:0] cand [$];
        for (int i = 0; i < NODES; i++)
        begin
            if (block_present[i] == want_present && (!ever_only || block_written[i]))
                cand.push_back(ID_W'(i));
        end
        ok = (cand.size() != 0);
        id = ok ? cand[$urandom_range(cand.size() - 1)] : '0;
    endfunction

    // Offer one request item, hold it until taken, then log its answer
    task automatic send_item(input action_t act, input logic [ID_W-1:0] id,
                             input logic [BYTES_W-1:0] bytes,
                             input logic typed, input result_t typed_res);
        result_t want;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        block_id    <= id;
        block_bytes <= bytes;
        do
            @(posedge clk);
        while (in_stall);
        want = apply_request(act, id, bytes);
        pending_answers.push_back(typed ? typed_res : want);
        case (act)
            ACT_INSERT:
            begin
                block_present[id] = 1'b1;
                block_written[id] = 1'b1;
            end
            ACT_REMOVE:
                block_present[id] = 1'b0;
            ACT_CLEAR:
            begin
                foreach (block_present[i])
                    block_present[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Drop valid and hold off until every answer is back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_failure(input string what, input result_t want,
                                input result_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t %s: want found=%0d block=%0d probes=%0d, got found=%0d block=%0d probes=%0d",
                     $realtime, what, want.found, want.block, want.probes,
                     got.found, got.block, got.probes);
    endtask

    // Stall the result channel at random
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Check each result item against the oldest awaited answer
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {found, found_block, probe_count};
            if (pending_answers.size() == 0)
                note_failure("result with none awaited", ZERO_RESULT, got);
            else
            begin
                want = pending_answers.pop_front();
                if (got.found !== want.found || got.block !== want.block ||
                    got.probes !== want.probes)
                    note_failure("mismatch", want, got);
            end
        end
    end

    // Give up on a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Main sequence: reset, directed table, three random phases, drain
    initial
    begin
        int               r;
        bit               ok;
        action_t          act;
        logic [ID_W-1:0]  id;
        logic [ID_W-1:0]  chosen;
        int               tx_pct [3];
        int               rx_pct [3];
        tx_pct = '{29, 64, 0};
        rx_pct = '{64, 29, 0};
        for (int k = 0; k < CLASSES; k++)
        begin
            head_block[k] = '0;
            live_class[k] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = tx_pct[0];
        rx_idle_pct = rx_pct[0];
        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].id, directed_rows[i].bytes,
                      directed_rows[i].typed, directed_rows[i].res);
        settle();

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = tx_pct[ph];
            rx_idle_pct = rx_pct[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(99);
                act = ACT_FIND;
                id = ID_W'($urandom_range(NODES - 1));
                ok = 1'b0;
                chosen = '0;
                // Mostly well-formed traffic, with a little double insert,
                // removal of absent blocks and clearing
                if (r < 1)
                    act = ACT_CLEAR;
                else if (r < 3)
                begin
                    pick_block(1'b1, 1'b0, chosen, ok);
                    if (ok)
                        act = ACT_INSERT;
                end
                else if (r < 5)
                begin
                    pick_block(1'b0, 1'b1, chosen, ok);
                    if (ok)
                        act = ACT_REMOVE;
                end
                else if (r < 45)
                begin
                    pick_block(1'b0, 1'b0, chosen, ok);
                    if (ok)
                        act = ACT_INSERT;
                end
                else if (r < 65)
                begin
                    pick_block(1'b1, 1'b0, chosen, ok);
                    if (ok)
                        act = ACT_REMOVE;
                end
                if (ok)
                    id = chosen;
                send_item(act, id, pick_size(), 1'b0, ZERO_RESULT);
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
